// ===== hw/rtl/cfe_pkg.sv =====
package cfe_pkg;

    // Default sizing
    localparam int STORE_DEPTH_DEF = 64;
    localparam int MAX_PAYLOAD_DEF = 50;

    // Frame layout
    localparam int HDR_BYTES = 10;
    localparam int CRC_BYTES = 4;
    localparam int MIN_FRAME = HDR_BYTES + CRC_BYTES;

    // Queue between scanner and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // CRC-32 (reflected)
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_first;
        logic       frame_last;
        logic       run_last;
    } res_t;

    // Scanner sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HDR,
        S_CHECK,
        S_CRC,
        S_CMP,
        S_EMIT,
        S_FINISH
    } scan_state_t;

    // One byte through the reflected CRC, a bit per step
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/crc_checked_frame_extractor.sv =====
// Sync-word deframer with CRC-32 check.
// Input channel s_valid/s_ready/s_rx_byte takes one received byte at a time
// into a circular byte store; a full store drops its oldest byte first.
// After each byte the store is rescanned from its oldest byte for a frame:
// sync word, 16-bit length, payload and little-endian reflected CRC-32.
// Result channel m_valid/m_ready carries every good frame byte by byte with
// frame_first/frame_last marks and run_last on the last byte from one input.
// cfg_wr_en/cfg_wr_data write the expected sync word; the user must do so
// only while idle, as the block does not enforce this. Each header attempt
// reads six store bytes; a frame is read once for the CRC pass and
// once more for emission if good, one store read per cycle at most, and
// emission waits for queue room. Bad candidates drop one byte and rescan.
// Results pass through a 4-entry queue and an output register, so a stalled
// receiver holds the scanner only once the queue, counting reads in flight,
// is full; s_ready stays low until all of this byte's results are queued.
// Reset empties the store, clears the sync word to zero, drops queued items.
module crc_checked_frame_extractor #(
    parameter int STORE_DEPTH = cfe_pkg::STORE_DEPTH_DEF,
    parameter int MAX_PAYLOAD = cfe_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_frame_first,
    output logic        m_frame_last,
    output logic        m_run_last,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic [15:0]                  sync_word_reg;
    logic                         q_push;
    cfe_pkg::res_t                q_push_data;
    logic                         q_pop;
    cfe_pkg::res_t                q_pop_data;
    logic                         q_empty;
    logic                         q_full;
    logic [cfe_pkg::QUEUE_CW-1:0] q_count;

    // Sync word register
    always_ff @(posedge aclk) begin
        if (!aresetn) sync_word_reg <= '0;
        else if (cfg_wr_en) sync_word_reg <= cfg_wr_data;
    end

    cfe_scan #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .sync_word (sync_word_reg),
        .push      (q_push),
        .push_data (q_push_data),
        .q_full    (q_full),
        .q_count   (q_count)
    );

    cfe_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty),
        .full      (q_full),
        .count     (q_count)
    );

    cfe_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_data        (q_pop_data),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_first (m_frame_first),
        .m_frame_last  (m_frame_last),
        .m_run_last    (m_run_last)
    );

endmodule

// ===== hw/rtl/cfe_fifo.sv =====
module cfe_fifo (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  cfe_pkg::res_t                push_data,
    input  logic                         pop,
    output cfe_pkg::res_t                pop_data,
    output logic                         empty,
    output logic                         full,
    output logic [cfe_pkg::QUEUE_CW-1:0] count
);

    cfe_pkg::res_t                 slot_reg [cfe_pkg::QUEUE_DEPTH];
    logic [cfe_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [cfe_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [cfe_pkg::QUEUE_CW-1:0]  count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == cfe_pkg::QUEUE_CW'(cfe_pkg::QUEUE_DEPTH));
    assign count    = count_reg;
    assign pop_data = slot_reg[rd_ptr_reg];

    // Pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hw/rtl/cfe_out.sv =====
module cfe_out (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  cfe_pkg::res_t q_data,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_frame_first,
    output logic          m_frame_last,
    output logic          m_run_last
);

    logic          valid_reg;
    cfe_pkg::res_t data_reg;

    // Reload the output register when empty or being taken
    assign q_pop = !q_empty && (!valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_ready) begin
            valid_reg <= !q_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) data_reg <= q_data;
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = data_reg.out_byte;
    assign m_frame_first = data_reg.frame_first;
    assign m_frame_last  = data_reg.frame_last;
    assign m_run_last    = data_reg.run_last;

endmodule

// ===== hw/rtl/cfe_scan.sv =====
module cfe_scan #(
    parameter int STORE_DEPTH = cfe_pkg::STORE_DEPTH_DEF,
    parameter int MAX_PAYLOAD = cfe_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_rx_byte,
    input  logic [15:0]                  sync_word,
    output logic                         push,
    output cfe_pkg::res_t                push_data,
    input  logic                         q_full,
    input  logic [cfe_pkg::QUEUE_CW-1:0] q_count
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int FW = $clog2(STORE_DEPTH + 1);

    cfe_pkg::scan_state_t state_reg, state_next;

    logic [7:0]    mem [STORE_DEPTH];
    logic [AW-1:0] head_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] off_reg;
    logic [FW-1:0] tag_reg;
    logic          inflight_reg;
    logic [7:0]    rd_data_reg;
    logic [15:0]   sync_rx_reg;
    logic [15:0]   plen_reg;
    logic [FW-1:0] flen_reg;
    logic [31:0]   crc_reg;
    logic [31:0]   rcv_crc_reg;
    logic          pend_valid_reg;
    logic [7:0]    pend_byte_reg;
    logic          pend_first_reg;
    logic          pend_last_reg;

    logic          rd_issue;
    logic          arr;
    logic          hdr_bad;
    logic          too_short;
    logic [16:0]   flen_full;
    logic          tag_last;
    logic [FW-1:0] crc_len;

    // Circular index: base plus offset, wrapped once
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [FW-1:0] n);
        logic [FW:0] s;
        s = {{(FW + 1 - AW){1'b0}}, base} + {1'b0, n};
        if (s >= (FW + 1)'(STORE_DEPTH)) s = s - (FW + 1)'(STORE_DEPTH);
        return s[AW-1:0];
    endfunction

    // Header and frame checks
    assign arr       = inflight_reg;
    assign hdr_bad   = (sync_rx_reg != sync_word) || (plen_reg > 16'(MAX_PAYLOAD));
    assign flen_full = 17'(cfe_pkg::MIN_FRAME) + {1'b0, plen_reg};
    assign too_short = {{(17 - FW){1'b0}}, fill_reg} < flen_full;
    assign tag_last  = (tag_reg == flen_reg - 1'b1);
    assign crc_len   = flen_reg - FW'(cfe_pkg::CRC_BYTES);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cfe_pkg::S_IDLE:   if (s_valid) state_next = cfe_pkg::S_SCAN;
            cfe_pkg::S_SCAN:   state_next = (fill_reg >= FW'(cfe_pkg::MIN_FRAME)) ?
                                            cfe_pkg::S_HDR : cfe_pkg::S_FINISH;
            cfe_pkg::S_HDR:    if (arr && tag_reg == FW'(5)) state_next = cfe_pkg::S_CHECK;
            cfe_pkg::S_CHECK: begin
                if (hdr_bad)        state_next = cfe_pkg::S_SCAN;
                else if (too_short) state_next = cfe_pkg::S_FINISH;
                else                state_next = cfe_pkg::S_CRC;
            end
            cfe_pkg::S_CRC:    if (arr && tag_last) state_next = cfe_pkg::S_CMP;
            cfe_pkg::S_CMP:    state_next = ((crc_reg ^ cfe_pkg::CRC_ONES) != rcv_crc_reg) ?
                                            cfe_pkg::S_SCAN : cfe_pkg::S_EMIT;
            cfe_pkg::S_EMIT:   if (arr && tag_last) state_next = cfe_pkg::S_SCAN;
            cfe_pkg::S_FINISH: if (!pend_valid_reg || !q_full) state_next = cfe_pkg::S_IDLE;
            default:           state_next = cfe_pkg::S_IDLE;
        endcase
    end

    // Outputs: handshake, store reads, queue pushes
    always_comb begin
        s_ready  = 1'b0;
        rd_issue = 1'b0;
        push     = 1'b0;
        unique case (state_reg)
            cfe_pkg::S_IDLE: s_ready = 1'b1;
            cfe_pkg::S_HDR:  rd_issue = (off_reg < FW'(6));
            cfe_pkg::S_CRC:  rd_issue = (off_reg < flen_reg);
            cfe_pkg::S_EMIT: begin
                rd_issue = (off_reg < flen_reg) &&
                           ((q_count + cfe_pkg::QUEUE_CW'(inflight_reg)) <
                            cfe_pkg::QUEUE_CW'(cfe_pkg::QUEUE_DEPTH));
                push     = arr && pend_valid_reg;
            end
            cfe_pkg::S_FINISH: push = pend_valid_reg && !q_full;
            default: ;
        endcase
        push_data.out_byte    = pend_byte_reg;
        push_data.frame_first = pend_first_reg;
        push_data.frame_last  = pend_last_reg;
        push_data.run_last    = (state_reg == cfe_pkg::S_FINISH);
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cfe_pkg::S_IDLE;
            head_reg       <= '0;
            fill_reg       <= '0;
            inflight_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            off_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            inflight_reg <= rd_issue;
            if (rd_issue) off_reg <= off_reg + 1'b1;
            unique case (state_reg)
                cfe_pkg::S_IDLE: begin
                    if (s_valid) begin
                        if (fill_reg == FW'(STORE_DEPTH)) head_reg <= wrap_add(head_reg, FW'(1));
                        else fill_reg <= fill_reg + 1'b1;
                    end
                end
                cfe_pkg::S_SCAN: off_reg <= '0;
                cfe_pkg::S_CHECK: begin
                    if (hdr_bad) begin
                        head_reg <= wrap_add(head_reg, FW'(1));
                        fill_reg <= fill_reg - 1'b1;
                    end
                end
                cfe_pkg::S_CMP: begin
                    off_reg <= '0;
                    if ((crc_reg ^ cfe_pkg::CRC_ONES) != rcv_crc_reg) begin
                        head_reg <= wrap_add(head_reg, FW'(1));
                        fill_reg <= fill_reg - 1'b1;
                    end
                end
                cfe_pkg::S_EMIT: begin
                    if (arr) begin
                        pend_valid_reg <= 1'b1;
                        if (tag_last) begin
                            head_reg <= wrap_add(head_reg, flen_reg);
                            fill_reg <= fill_reg - flen_reg;
                        end
                    end
                end
                cfe_pkg::S_FINISH: if (!q_full) pend_valid_reg <= 1'b0;
                default: ;
            endcase
            if (state_reg == cfe_pkg::S_CHECK) off_reg <= '0;
        end
    end

    // Byte store: write on accept, registered read
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            if (fill_reg == FW'(STORE_DEPTH)) mem[head_reg] <= s_rx_byte;
            else mem[wrap_add(head_reg, fill_reg)] <= s_rx_byte;
        end
        if (rd_issue) begin
            rd_data_reg <= mem[wrap_add(head_reg, off_reg)];
            tag_reg     <= off_reg;
        end
    end

    // Header capture, CRC accumulation, pending result
    always_ff @(posedge aclk) begin
        if (state_reg == cfe_pkg::S_CHECK) begin
            flen_reg <= flen_full[FW-1:0];
            crc_reg  <= cfe_pkg::CRC_ONES;
        end
        if (arr) begin
            unique case (state_reg)
                cfe_pkg::S_HDR: begin
                    if (tag_reg == FW'(0)) sync_rx_reg[7:0]  <= rd_data_reg;
                    if (tag_reg == FW'(1)) sync_rx_reg[15:8] <= rd_data_reg;
                    if (tag_reg == FW'(4)) plen_reg[7:0]     <= rd_data_reg;
                    if (tag_reg == FW'(5)) plen_reg[15:8]    <= rd_data_reg;
                end
                cfe_pkg::S_CRC: begin
                    if (tag_reg < crc_len) crc_reg <= cfe_pkg::crc_byte(crc_reg, rd_data_reg);
                    else rcv_crc_reg <= {rd_data_reg, rcv_crc_reg[31:8]};
                end
                cfe_pkg::S_EMIT: begin
                    pend_byte_reg  <= rd_data_reg;
                    pend_first_reg <= (tag_reg == '0);
                    pend_last_reg  <= tag_last;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    // Fill never passes the store size
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(STORE_DEPTH))
        else $error("store fill overflow");

    // A push never meets a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("push into full queue");

    // Nothing held back when a new byte is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_valid_reg && !inflight_reg)
        else $error("input taken with result pending");

    // A read is followed by a scanning state, never by idle or finish
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_issue |=> (state_reg == cfe_pkg::S_HDR || state_reg == cfe_pkg::S_CHECK ||
                      state_reg == cfe_pkg::S_CRC || state_reg == cfe_pkg::S_CMP ||
                      state_reg == cfe_pkg::S_EMIT || state_reg == cfe_pkg::S_SCAN))
        else $error("store read outside scan");
`endif

endmodule

// ===== verif/crc_checked_frame_extractor_tb.sv =====
`timescale 1ns / 1ps

module crc_checked_frame_extractor_tb;

    localparam int DEPTH      = cfe_pkg::STORE_DEPTH_DEF;
    localparam int MAX_PLEN   = cfe_pkg::MAX_PAYLOAD_DEF;
    localparam int SETTLE     = 6000;
    localparam int STALL_MAX  = 18;
    localparam int WDOG_LIMIT = 40000;

    // Kinds of frame the stimulus builds
    typedef enum int {
        FR_GOOD,
        FR_BAD_SYNC,
        FR_OVERSIZE,
        FR_BAD_CRC
    } frame_kind_t;

    typedef struct {
        logic [7:0] rx;
        int         n_typed;    // results this item must cause, -1 when left to the model
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_frame_first;
    logic        m_frame_last;
    logic        m_run_last;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    // Model state
    logic [7:0]    rx_store[$];
    logic [15:0]   sync_cfg;
    cfe_pkg::res_t frame_bytes_due[$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  steady_flow = 1'b0;
    int  last_push;

    crc_checked_frame_extractor dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_first (m_frame_first),
        .m_frame_last  (m_frame_last),
        .m_run_last    (m_run_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // Reflected CRC-32 over the first len bytes of a byte list
    function automatic logic [31:0] frame_crc(ref logic [7:0] q[$], input int len);
        logic [31:0] c;
        c = 32'hFFFF_FFFF;
        for (int i = 0; i < len; i++) begin
            c ^= {24'd0, q[i]};
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
            end
        end
        return c ^ 32'hFFFF_FFFF;
    endfunction

    // Append one byte, rescan the store and queue every frame byte it releases
    function automatic int absorb_byte(input logic [7:0] rx);
        int n;
        int plen;
        int flen;
        logic [31:0] got;
        cfe_pkg::res_t r;
        n = 0;
        if (rx_store.size() >= DEPTH) void'(rx_store.pop_front());
        rx_store.push_back(rx);
        while (rx_store.size() >= cfe_pkg::HDR_BYTES + cfe_pkg::CRC_BYTES) begin
            if ({rx_store[1], rx_store[0]} != sync_cfg) begin
                void'(rx_store.pop_front());
                continue;
            end
            plen = {rx_store[5], rx_store[4]};
            if (plen > MAX_PLEN) begin
                void'(rx_store.pop_front());
                continue;
            end
            flen = cfe_pkg::HDR_BYTES + plen + cfe_pkg::CRC_BYTES;
            if (rx_store.size() < flen) break;
            got = {rx_store[flen-1], rx_store[flen-2], rx_store[flen-3], rx_store[flen-4]};
            if (got != frame_crc(rx_store, cfe_pkg::HDR_BYTES + plen)) begin
                void'(rx_store.pop_front());
                continue;
            end
            for (int i = 0; i < flen; i++) begin
                r.out_byte    = rx_store[0];
                r.frame_first = (i == 0);
                r.frame_last  = (i == flen - 1);
                r.run_last    = 1'b0;
                void'(rx_store.pop_front());
                frame_bytes_due.push_back(r);
                n++;
            end
        end
        if (n > 0) frame_bytes_due[frame_bytes_due.size()-1].run_last = 1'b1;
        return n;
    endfunction

    // Send one item; entered and left at a falling edge, valid held when no gap
    task automatic send_byte(input logic [7:0] rx, input bit no_gap);
        int gap;
        gap = (no_gap || steady_flow) ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        last_push = absorb_byte(rx);
        @(negedge aclk);
    endtask

    // Build a frame of the given kind and send it
    task automatic send_frame(input frame_kind_t kind, input int plen, input bit all_ones);
        logic [7:0] f[$];
        logic [31:0] c;
        int len_field;
        len_field = (kind == FR_OVERSIZE) ? $urandom_range(MAX_PLEN + 1, 16'hFFFF) : plen;
        f.push_back(sync_cfg[7:0]);
        f.push_back(sync_cfg[15:8]);
        if (kind == FR_BAD_SYNC) f[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        f.push_back(all_ones ? 8'hFF : 8'($urandom));
        f.push_back(all_ones ? 8'hFF : 8'($urandom));
        f.push_back(len_field[7:0]);
        f.push_back(len_field[15:8]);
        for (int i = 0; i < 4 + plen; i++) f.push_back(all_ones ? 8'hFF : 8'($urandom));
        c = frame_crc(f, f.size());
        if (kind == FR_BAD_CRC) c ^= 32'(1) << $urandom_range(0, 31);
        for (int i = 0; i < 4; i++) f.push_back(c[8*i +: 8]);
        foreach (f[i]) send_byte(f[i], 1'b0);
    endtask

    // Write the sync word with the block idle
    task automatic write_sync(input logic [15:0] w);
        s_valid <= 1'b0;
        wait (frame_bytes_due.size() == 0);
        repeat (SETTLE) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sync_cfg = w;
    endtask

    // Receiver stalls
    always @(negedge aclk) begin
        if (steady_flow) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, STALL_MAX) == 0) || ($urandom_range(0, 2) == 0);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        cfe_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_bytes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item byte=%h first=%b last=%b run_last=%b",
                             m_out_byte, m_frame_first, m_frame_last, m_run_last);
            end else begin
                want = frame_bytes_due.pop_front();
                if (want.out_byte != m_out_byte || want.frame_first != m_frame_first ||
                    want.frame_last != m_frame_last || want.run_last != m_run_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("item mismatch: want %h/%b/%b/%b got %h/%b/%b/%b",
                                 want.out_byte, want.frame_first, want.frame_last,
                                 want.run_last, m_out_byte, m_frame_first,
                                 m_frame_last, m_run_last);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("crc_checked_frame_extractor verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        dir_row_t rows[$];
        int sent;
        frame_kind_t k;
        int pick;
        int plen_pick;
        int n_noise;

        sync_cfg = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Fewer than a minimum frame's worth of bytes after reset: nothing can come out
        rows = '{'{8'h00, 0}, '{8'hFF, 0}, '{8'h55, 0}, '{8'hAA, 0}, '{8'h01, 0},
                 '{8'h80, 0}, '{8'h7F, 0}, '{8'hFE, 0}, '{8'h00, 0}, '{8'h00, 0},
                 '{8'h0F, 0}, '{8'hF0, 0}};
        foreach (rows[i]) begin
            send_byte(rows[i].rx, 1'b0);
            if (rows[i].n_typed >= 0 && last_push != rows[i].n_typed) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed item %0d: model gives %0d items, table says %0d",
                             i, last_push, rows[i].n_typed);
            end
        end

        // Directed frames: zero payload, every rejection, all-ones content
        write_sync(16'h0000);
        send_frame(FR_GOOD, 0, 1'b0);
        send_frame(FR_BAD_SYNC, 0, 1'b0);
        send_frame(FR_OVERSIZE, 0, 1'b0);
        send_frame(FR_BAD_CRC, 0, 1'b0);
        send_frame(FR_GOOD, 1, 1'b1);

        // Hold the sender until everything has drained
        s_valid <= 1'b0;
        wait (frame_bytes_due.size() == 0);
        @(negedge aclk);

        // Random phases: all-ones sync word, then a random one with a free-running receiver
        for (int ph = 0; ph < 2; ph++) begin
            write_sync(ph == 0 ? 16'hFFFF : 16'($urandom));
            steady_flow = (ph == 1);
            sent = 0;
            while (sent < 10) begin
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    n_noise = $urandom_range(1, 4);
                    repeat (n_noise) send_byte(8'($urandom), 1'b0);
                    sent += n_noise;
                end else begin
                    k = pick < 7 ? FR_GOOD : frame_kind_t'($urandom_range(1, 3));
                    plen_pick = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_PLEN)
                                                            : $urandom_range(0, 6);
                    send_frame(k, plen_pick, 1'b0);
                    sent += cfe_pkg::MIN_FRAME + plen_pick;
                end
            end
            steady_flow = 1'b0;
        end

        s_valid <= 1'b0;
        wait (frame_bytes_due.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && frame_bytes_due.size() == 0) begin
            $display("crc_checked_frame_extractor verification clean");
        end else begin
            $display("crc_checked_frame_extractor verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cfe_pkg.sv
hw/rtl/cfe_fifo.sv
hw/rtl/cfe_out.sv
hw/rtl/cfe_scan.sv
hw/rtl/crc_checked_frame_extractor.sv
verif/crc_checked_frame_extractor_tb.sv
